// File: rtl/aocs_pkg.sv
// Shared constants, types and mode codes for the overlay crossfade switch.
package aocs_pkg;

  localparam int CHANNELS        = 2;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int POS_BITS   = 20;
  localparam int LEN_BITS   = 21;
  localparam int STEP_BITS  = 25;
  localparam int GAIN_BITS  = 25;
  localparam int GAIN_FRAC  = 24;
  localparam int PROD_BITS  = POS_BITS + STEP_BITS;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 25;

  localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCK_LEN = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FADE_STEP = 2'd1;

  localparam logic [LEN_BITS-1:0]  MAX_BLOCK       = 21'd1048576;
  localparam logic [LEN_BITS-1:0]  BLOCK_LEN_RESET = 21'd4800;
  localparam logic [STEP_BITS-1:0] FADE_STEP_RESET = 25'd3495;
  localparam logic [GAIN_BITS-1:0] GAIN_ONE        = 25'd16777216;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_PASS_MAIN    = 2'd0;
  localparam mode_t MODE_PASS_OVL     = 2'd1;
  localparam mode_t MODE_FADE_TO_OVL  = 2'd2;
  localparam mode_t MODE_FADE_TO_MAIN = 2'd3;

  typedef struct packed {
    mode_t               mode;
    logic                last;
    logic [POS_BITS-1:0] k_out;
    logic [POS_BITS-1:0] k_in;
  } item_ctrl_t;

  typedef struct packed {
    mode_t mode;
    logic  last;
  } tag_t;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } load_t;

endpackage

// File: rtl/audio_overlay_crossfade_switch.sv
// Overlay crossfade switch: mixes a main and an overlay stereo stream per block of samples.
// One result beat leaves for every input beat, one beat per clock sustained while out_stall
// is low. The five stages are: block sequencing and input capture, the gain multiply, the
// gain clip to unity, the per-channel sample multiplies (two per lane, one lane per channel),
// and the round, saturate and select stage that forms the output register. Each stage moves
// up whenever the one after it is empty or moving, so in_stall rises only when all five
// stages hold beats and out_stall is high.
// The user must write block_len and fade_step only while no beat is in flight; the block does not enforce it.
module audio_overlay_crossfade_switch import aocs_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] main_left,
  input  logic signed [SAMPLE_BITS-1:0] main_right,
  input  logic signed [SAMPLE_BITS-1:0] overlay_left,
  input  logic signed [SAMPLE_BITS-1:0] overlay_right,
  input  logic                          overlay_present,
  input  logic                          disabled,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_left,
  output logic signed [SAMPLE_BITS-1:0] out_right,
  output logic                          block_last,
  output logic [1:0]                    block_mode
);

  logic [LEN_BITS-1:0]  block_len;
  logic [STEP_BITS-1:0] fade_step;

  logic [5:1] v;
  logic [5:1] rdy;
  logic       accept;
  load_t      load;

  item_ctrl_t item, item_s1;
  tag_t       tag_s2, tag_s3, tag_s4, tag_s5;

  logic signed [SAMPLE_BITS-1:0] main_in  [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] ovl_in   [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] main_s1  [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] ovl_s1   [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] lane_out [CHANNELS];

  logic [GAIN_BITS-1:0] gain_out, gain_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_len <= BLOCK_LEN_RESET;
      fade_step <= FADE_STEP_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_BLOCK_LEN) begin
        block_len <= cfg_data[LEN_BITS-1:0];
      end else if (cfg_index == REG_FADE_STEP) begin
        fade_step <= cfg_data[STEP_BITS-1:0];
      end
    end
  end

  always_comb begin
    rdy[5] = !v[5] || !out_stall;
    rdy[4] = !v[4] || rdy[5];
    rdy[3] = !v[3] || rdy[4];
    rdy[2] = !v[2] || rdy[3];
    rdy[1] = !v[1] || rdy[2];
  end

  assign in_stall = !rdy[1];
  assign accept   = in_valid && rdy[1];
  assign load.s2  = rdy[2] && v[1];
  assign load.s3  = rdy[3] && v[2];
  assign load.s4  = rdy[4] && v[3];
  assign load.s5  = rdy[5] && v[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) v[1] <= in_valid;
      if (rdy[2]) v[2] <= v[1];
      if (rdy[3]) v[3] <= v[2];
      if (rdy[4]) v[4] <= v[3];
      if (rdy[5]) v[5] <= v[4];
    end
  end

  aocs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .present   (overlay_present),
    .dis       (disabled),
    .block_len (block_len),
    .item      (item)
  );

  assign main_in[0] = main_left;
  assign main_in[1] = main_right;
  assign ovl_in[0]  = overlay_left;
  assign ovl_in[1]  = overlay_right;

  always_ff @(posedge clk) begin
    if (accept) begin
      item_s1 <= item;
      main_s1 <= main_in;
      ovl_s1  <= ovl_in;
    end
    if (load.s2) tag_s2 <= '{mode: item_s1.mode, last: item_s1.last};
    if (load.s3) tag_s3 <= tag_s2;
    if (load.s4) tag_s4 <= tag_s3;
    if (load.s5) tag_s5 <= tag_s4;
  end

  aocs_gain u_gain (
    .clk       (clk),
    .load      (load),
    .fade_step (fade_step),
    .k_out     (item_s1.k_out),
    .k_in      (item_s1.k_in),
    .gain_out  (gain_out),
    .gain_in   (gain_in)
  );

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    aocs_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .clk      (clk),
      .load     (load),
      .main_s1  (main_s1[c]),
      .ovl_s1   (ovl_s1[c]),
      .gain_out (gain_out),
      .gain_in  (gain_in),
      .mode_s3  (tag_s3.mode),
      .mode_s4  (tag_s4.mode),
      .result   (lane_out[c])
    );
  end

  assign out_valid  = v[5];
  assign out_left   = lane_out[0];
  assign out_right  = lane_out[1];
  assign block_last = tag_s5.last;
  assign block_mode = tag_s5.mode;

endmodule

// File: rtl/aocs_ctrl.sv
// Block sequencer: position in the block, mode choice and gain indexes per beat.
module aocs_ctrl import aocs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 present,
  input  logic                 dis,
  input  logic [LEN_BITS-1:0]  block_len,
  output item_ctrl_t           item
);

  logic [POS_BITS-1:0] pos;
  logic [POS_BITS-1:0] pos_next;
  logic                first_block, first_block_next;
  logic                prior_known, prior_known_next;
  logic                prior_disabled, prior_disabled_next;
  logic                fade_done, fade_done_next;
  logic                fade_toward_main, fade_toward_main_next;
  logic                overlay_ended, overlay_ended_next;
  mode_t               current_mode, current_mode_next;

  logic [LEN_BITS-1:0] n;
  logic [LEN_BITS-1:0] pos_wide;
  logic [LEN_BITS-1:0] pos_inc;
  logic [LEN_BITS-1:0] remain;
  logic                last;

  always_comb begin
    if (block_len == '0) begin
      n = LEN_BITS'(1);
    end else if (block_len > MAX_BLOCK) begin
      n = MAX_BLOCK;
    end else begin
      n = block_len;
    end
  end

  assign pos_wide = {1'b0, pos};
  assign pos_inc  = pos_wide + LEN_BITS'(1);
  assign last     = (pos_inc >= n);
  assign remain   = n - LEN_BITS'(1) - pos_wide;
  assign pos_next = last ? '0 : pos_inc[POS_BITS-1:0];

  always_comb begin
    first_block_next      = first_block;
    prior_known_next      = prior_known;
    prior_disabled_next   = prior_disabled;
    fade_done_next        = fade_done;
    fade_toward_main_next = fade_toward_main;
    overlay_ended_next    = overlay_ended | ~present;
    current_mode_next     = current_mode;
    if (pos == '0) begin
      if (first_block) begin
        first_block_next  = 1'b0;
        current_mode_next = overlay_ended_next ? MODE_PASS_MAIN : MODE_FADE_TO_OVL;
      end else begin
        if (!prior_known) begin
          prior_known_next    = 1'b1;
          prior_disabled_next = dis;
          fade_done_next      = 1'b1;
        end
        if (prior_disabled_next != dis) begin
          fade_toward_main_next = dis;
          prior_disabled_next   = dis;
          fade_done_next        = 1'b0;
        end
        if (overlay_ended_next) begin
          current_mode_next = MODE_PASS_MAIN;
        end else if (!fade_done_next) begin
          current_mode_next = fade_toward_main_next ? MODE_FADE_TO_MAIN : MODE_FADE_TO_OVL;
          fade_done_next    = 1'b1;
        end else begin
          current_mode_next = dis ? MODE_PASS_MAIN : MODE_PASS_OVL;
        end
      end
    end
  end

  always_comb begin
    item.mode  = current_mode_next;
    item.last  = last;
    item.k_in  = pos;
    item.k_out = (pos_wide < n) ? remain[POS_BITS-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos              <= '0;
      first_block      <= 1'b1;
      prior_known      <= 1'b0;
      prior_disabled   <= 1'b0;
      fade_done        <= 1'b0;
      fade_toward_main <= 1'b0;
      overlay_ended    <= 1'b0;
      current_mode     <= MODE_PASS_MAIN;
    end else if (accept) begin
      pos              <= pos_next;
      first_block      <= first_block_next;
      prior_known      <= prior_known_next;
      prior_disabled   <= prior_disabled_next;
      fade_done        <= fade_done_next;
      fade_toward_main <= fade_toward_main_next;
      overlay_ended    <= overlay_ended_next;
      current_mode     <= current_mode_next;
    end
  end

endmodule

// File: rtl/aocs_gain.sv
// Gain unit: position times fade step, then clip to unity, shared by all lanes.
module aocs_gain import aocs_pkg::*; (
  input  logic                 clk,
  input  load_t                load,
  input  logic [STEP_BITS-1:0] fade_step,
  input  logic [POS_BITS-1:0]  k_out,
  input  logic [POS_BITS-1:0]  k_in,
  output logic [GAIN_BITS-1:0] gain_out,
  output logic [GAIN_BITS-1:0] gain_in
);

  logic [PROD_BITS-1:0] prod_out;
  logic [PROD_BITS-1:0] prod_in;

  always_ff @(posedge clk) begin
    if (load.s2) begin
      prod_out <= PROD_BITS'(k_out) * PROD_BITS'(fade_step);
      prod_in  <= PROD_BITS'(k_in) * PROD_BITS'(fade_step);
    end
  end

  always_ff @(posedge clk) begin
    if (load.s3) begin
      gain_out <= (prod_out > PROD_BITS'(GAIN_ONE)) ? GAIN_ONE : prod_out[GAIN_BITS-1:0];
      gain_in  <= (prod_in > PROD_BITS'(GAIN_ONE)) ? GAIN_ONE : prod_in[GAIN_BITS-1:0];
    end
  end

endmodule

// File: rtl/aocs_lane.sv
// One channel lane: weight both streams, round half-up, saturate, or pass through.
module aocs_lane import aocs_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  load_t                         load,
  input  logic signed [SAMPLE_BITS-1:0] main_s1,
  input  logic signed [SAMPLE_BITS-1:0] ovl_s1,
  input  logic [GAIN_BITS-1:0]          gain_out,
  input  logic [GAIN_BITS-1:0]          gain_in,
  input  mode_t                         mode_s3,
  input  mode_t                         mode_s4,
  output logic signed [SAMPLE_BITS-1:0] result
);

  localparam int PROD_W = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int Q_W    = SUM_W - GAIN_FRAC;
  localparam logic signed [SUM_W-1:0] ROUND =
    {{(SUM_W-GAIN_FRAC){1'b0}}, 1'b1, {(GAIN_FRAC-1){1'b0}}};

  logic signed [SAMPLE_BITS-1:0] main_s2, ovl_s2, main_s3, ovl_s3;
  logic signed [SAMPLE_BITS-1:0] lead, trail, pass_sel, pass_s4;
  logic signed [PROD_W-1:0]      prod_a, prod_b;
  logic signed [SUM_W-1:0]       sum;
  logic [Q_W-1:0]                q;
  logic [Q_W-SAMPLE_BITS:0]      q_top;
  logic [SAMPLE_BITS-1:0]        mixed;
  logic                          fade_s4;

  always_ff @(posedge clk) begin
    if (load.s2) begin
      main_s2 <= main_s1;
      ovl_s2  <= ovl_s1;
    end
    if (load.s3) begin
      main_s3 <= main_s2;
      ovl_s3  <= ovl_s2;
    end
  end

  assign lead     = (mode_s3 == MODE_FADE_TO_MAIN) ? ovl_s3 : main_s3;
  assign trail    = (mode_s3 == MODE_FADE_TO_MAIN) ? main_s3 : ovl_s3;
  assign pass_sel = (mode_s3 == MODE_PASS_OVL) ? ovl_s3 : main_s3;

  always_ff @(posedge clk) begin
    if (load.s4) begin
      prod_a  <= lead * $signed({1'b0, gain_out});
      prod_b  <= trail * $signed({1'b0, gain_in});
      pass_s4 <= pass_sel;
    end
  end

  assign sum   = SUM_W'(prod_a) + SUM_W'(prod_b) + ROUND;
  assign q     = sum[SUM_W-1:GAIN_FRAC];
  assign q_top = q[Q_W-1:SAMPLE_BITS-1];

  always_comb begin
    if ((&q_top) || !(|q_top)) begin
      mixed = q[SAMPLE_BITS-1:0];
    end else if (q[Q_W-1]) begin
      mixed = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      mixed = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  assign fade_s4 = (mode_s4 == MODE_FADE_TO_OVL) || (mode_s4 == MODE_FADE_TO_MAIN);

  always_ff @(posedge clk) begin
    if (load.s5) begin
      result <= fade_s4 ? $signed(mixed) : pass_s4;
    end
  end

endmodule
